FILE: hw/rtl/grid_rectangle_collision_map_macros.svh
// Assertion macros for the grid rectangle collision map.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef GRID_RECTANGLE_COLLISION_MAP_MACROS_SVH
`define GRID_RECTANGLE_COLLISION_MAP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication under asynchronous active-low reset
`define GRCM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("grcm assertion failed");
// Next-cycle implication under asynchronous active-low reset
`define GRCM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("grcm assertion failed");
`else
`define GRCM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define GRCM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/grcm_pkg.sv
// Shared constants, operation codes and handoff structs for the collision map.
// No dependencies; used by grcm_scan and grid_rectangle_collision_map.
`default_nettype none

package grcm_pkg;

	// Default grid geometry and stored ID width
	localparam int GRID_COLS_DEF = 64;
	localparam int GRID_ROWS_DEF = 64;
	localparam int ID_BITS_DEF   = 8;

	// Coordinate width: position plus the largest look-ahead offset plus rectangle size
	localparam int CW = 11;

	// Operation codes
	localparam logic [1:0] FUNC_CHECK = 2'd0;
	localparam logic [1:0] FUNC_STAMP = 2'd1;
	localparam logic [1:0] FUNC_ERASE = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_MAP_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_MAP_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_WALL_CODE  = 2'd2;

	// Command handed to the scan sequencer
	typedef struct packed {
		logic [1:0]    func;
		logic [CW-1:0] x0;
		logic [CW-1:0] y0;
		logic [6:0]    w;
		logic [6:0]    h;
		logic [7:0]    id;
		logic [6:0]    cols;
		logic [6:0]    rows;
		logic [7:0]    wall;
	} cmd_t;

	// Status and result returned by the scan sequencer
	typedef struct packed {
		logic       ready;
		logic       res_valid;
		logic [7:0] hit;
		logic       done;
	} stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/grcm_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module grcm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: hw/rtl/grcm_scan.sv
// Rectangle scan sequencer: walks the cells of a rectangle one per cycle through
// a read/modify/write pipeline on the grid RAM. Depends on grcm_pkg and grcm_ram.
`default_nettype none
`include "grid_rectangle_collision_map_macros.svh"

module grcm_scan #(
	parameter int GRID_COLS = grcm_pkg::GRID_COLS_DEF,
	parameter int GRID_ROWS = grcm_pkg::GRID_ROWS_DEF,
	parameter int ID_BITS   = grcm_pkg::ID_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  grcm_pkg::cmd_t  cmd,
	input  logic            res_ready,
	output grcm_pkg::stat_t stat
);

	localparam int DEPTH = GRID_COLS * GRID_ROWS;
	localparam int AW    = $clog2(DEPTH);
	localparam int XB    = $clog2(GRID_COLS);
	localparam int YB    = $clog2(GRID_ROWS);
	localparam int CW    = grcm_pkg::CW;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_RUN   = 3'd2;
	localparam logic [2:0] S_DRAIN = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0]         state_q;
	logic [AW-1:0]      clr_q;
	logic [1:0]         func_q;
	logic [CW-1:0]      x_q;
	logic [CW-1:0]      y_q;
	logic [CW-1:0]      x0_q;
	logic [CW-1:0]      x_last_q;
	logic [CW-1:0]      y_last_q;
	logic [ID_BITS-1:0] id_q;
	logic [6:0]         cols_q;
	logic [6:0]         rows_q;
	logic [7:0]         wall_code_q;
	logic               wall_q;
	logic               done_q;
	logic [ID_BITS-1:0] hit_q;
	logic               s1_valid_q;
	logic [AW-1:0]      s1_addr_s1;

	logic               cell_off;
	logic               issue;
	logic               wall_hit;
	logic               func_ok;
	logic [AW-1:0]      rd_addr;
	logic [ID_BITS-1:0] rdata;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [ID_BITS-1:0] ram_wdata;

	// Locate the current cell: off the map, or its RAM address
	always_comb begin
		cell_off = x_q[CW-1] || (x_q >= CW'(cols_q)) || y_q[CW-1] || (y_q >= CW'(rows_q));
		rd_addr  = AW'(y_q[YB-1:0] * GRID_COLS) + AW'(x_q[XB-1:0]);
		issue    = (state_q == S_RUN) && !cell_off;
		wall_hit = (state_q == S_RUN) && cell_off && (func_q == grcm_pkg::FUNC_CHECK);
		func_ok  = cmd.func inside {grcm_pkg::FUNC_CHECK, grcm_pkg::FUNC_STAMP,
			grcm_pkg::FUNC_ERASE};
	end

	// Write port: zero sweep after reset, else stamp or matching erase from stage 1
	always_comb begin
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = s1_valid_q && ((func_q == grcm_pkg::FUNC_STAMP) ||
				((func_q == grcm_pkg::FUNC_ERASE) && (rdata == id_q)));
			ram_waddr = s1_addr_s1;
			ram_wdata = (func_q == grcm_pkg::FUNC_STAMP) ? id_q : '0;
		end
	end

	grcm_ram #(
		.WIDTH(ID_BITS),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	// Sequencer: clear sweep, idle, cell walk, drain, result hold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			func_q     <= grcm_pkg::FUNC_CHECK;
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= issue;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						func_q <= cmd.func;
						if (!func_ok || (cmd.w == '0) || (cmd.h == '0)) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_RUN;
						end
					end
				end
				S_RUN: begin
					if (wall_hit || ((x_q == x_last_q) && (y_q == y_last_q))) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Walk coordinates and collect the check result
	always_ff @(posedge clk) begin
		s1_addr_s1 <= rd_addr;
		if ((state_q == S_IDLE) && start) begin
			x_q         <= cmd.x0;
			y_q         <= cmd.y0;
			x0_q        <= cmd.x0;
			x_last_q    <= cmd.x0 + CW'(cmd.w) - CW'(1);
			y_last_q    <= cmd.y0 + CW'(cmd.h) - CW'(1);
			id_q        <= ID_BITS'(cmd.id);
			cols_q      <= cmd.cols;
			rows_q      <= cmd.rows;
			wall_code_q <= cmd.wall;
			wall_q      <= 1'b0;
			done_q      <= func_ok;
			hit_q       <= '0;
		end else begin
			// advance in raster order
			if (state_q == S_RUN) begin
				if (wall_hit) begin
					wall_q <= 1'b1;
				end else if (x_q == x_last_q) begin
					x_q <= x0_q;
					y_q <= y_q + CW'(1);
				end else begin
					x_q <= x_q + CW'(1);
				end
			end
			// keep the last non-empty occupant
			if (s1_valid_q && (func_q == grcm_pkg::FUNC_CHECK) && (rdata != '0)) begin
				hit_q <= rdata;
			end
		end
	end

	always_comb begin
		stat.ready     = (state_q == S_IDLE);
		stat.res_valid = (state_q == S_DONE);
		stat.hit       = wall_q ? wall_code_q : 8'(hit_q);
		stat.done      = done_q;
	end

	`GRCM_ASSERT_IMPLY(a_s1_in_walk, clk, arst_n, s1_valid_q, (state_q == S_RUN || state_q == S_DRAIN))
	`GRCM_ASSERT_IMPLY(a_check_no_write, clk, arst_n, (state_q != S_CLEAR && func_q == grcm_pkg::FUNC_CHECK), !ram_we)
	`GRCM_ASSERT_IMPLY(a_start_idle, clk, arst_n, start, (state_q == S_IDLE))

endmodule

`default_nettype wire

FILE: hw/rtl/grid_rectangle_collision_map.sv
// Channel   Direction  Handshake            Beat contents
// in        to block   in_valid/in_stall    func, rectangle, look-ahead, owner_id
// out       from block out_valid/out_stall  hit_id, op_done
// cfg       to block   cfg_we               cfg_index, cfg_data
//
// An operation walks its rectangle one cell per cycle through the grid RAM port;
// a check stops at the first off-map cell.
// After reset a clearing pass writes zero to all GRID_COLS * GRID_ROWS cells, one per
// cycle, with in_stall high; configuration writes are taken during it.
// The result sits in an output register, so the next beat is taken while it waits;
// a new result is held back only while out_stall keeps the previous one.
// Depends on grcm_pkg, grcm_scan, grcm_ram and the macros header.
`default_nettype none
`include "grid_rectangle_collision_map_macros.svh"

module grid_rectangle_collision_map #(
	parameter int GRID_COLS = grcm_pkg::GRID_COLS_DEF,
	parameter int GRID_ROWS = grcm_pkg::GRID_ROWS_DEF,
	parameter int ID_BITS   = grcm_pkg::ID_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        func,
	input  logic signed [8:0] pos_x,
	input  logic signed [8:0] pos_y,
	input  logic [6:0]        rect_width,
	input  logic [6:0]        rect_height,
	input  logic signed [5:0] momentum_x,
	input  logic signed [5:0] momentum_y,
	input  logic signed [5:0] excess_x,
	input  logic signed [5:0] excess_y,
	input  logic [2:0]        step_multiplier,
	input  logic [7:0]        owner_id,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        hit_id,
	output logic              op_done,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [7:0]        cfg_data
);

	localparam int CW = grcm_pkg::CW;

	logic [6:0]             map_width_q;
	logic [6:0]             map_height_q;
	logic [7:0]             wall_code_q;
	logic                   out_valid_q;
	logic [7:0]             hit_q;
	logic                   done_q;

	logic                   accept;
	logic                   res_ready;
	logic signed [CW-1:0]   px_w;
	logic signed [CW-1:0]   py_w;
	logic signed [CW-1:0]   mx_w;
	logic signed [CW-1:0]   my_w;
	logic signed [CW-1:0]   ex_w;
	logic signed [CW-1:0]   ey_w;
	logic signed [CW-1:0]   mult_w;
	grcm_pkg::cmd_t         cmd;
	grcm_pkg::stat_t        stat;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q  <= 7'd64;
			map_height_q <= 7'd64;
			wall_code_q  <= 8'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				grcm_pkg::CFG_MAP_WIDTH:  map_width_q  <= cfg_data[6:0];
				grcm_pkg::CFG_MAP_HEIGHT: map_height_q <= cfg_data[6:0];
				grcm_pkg::CFG_WALL_CODE:  wall_code_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Build the command: look-ahead shift for checks, map size saturated to the grid
	always_comb begin
		px_w   = CW'(pos_x);
		py_w   = CW'(pos_y);
		mx_w   = CW'(momentum_x);
		my_w   = CW'(momentum_y);
		ex_w   = CW'(excess_x);
		ey_w   = CW'(excess_y);
		mult_w = CW'(step_multiplier);
		cmd.func = func;
		if ((func == grcm_pkg::FUNC_CHECK) && (step_multiplier != '0)) begin
			cmd.x0 = px_w + mx_w * mult_w + ex_w;
			cmd.y0 = py_w + my_w * mult_w + ey_w;
		end else begin
			cmd.x0 = px_w;
			cmd.y0 = py_w;
		end
		cmd.w    = rect_width;
		cmd.h    = rect_height;
		cmd.id   = owner_id;
		cmd.cols = (int'(map_width_q) > GRID_COLS) ? 7'(GRID_COLS) : map_width_q;
		cmd.rows = (int'(map_height_q) > GRID_ROWS) ? 7'(GRID_ROWS) : map_height_q;
		cmd.wall = wall_code_q;
	end

	assign in_stall  = !stat.ready;
	assign accept    = in_valid && stat.ready;
	assign res_ready = !out_valid_q || !out_stall;

	grcm_scan #(
		.GRID_COLS(GRID_COLS),
		.GRID_ROWS(GRID_ROWS),
		.ID_BITS  (ID_BITS)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.cmd      (cmd),
		.res_ready(res_ready),
		.stat     (stat)
	);

	// Output register: load a finished result when the slot is free, drop it when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= stat.res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && stat.res_valid) begin
			hit_q  <= stat.hit;
			done_q <= stat.done;
		end
	end

	assign out_valid = out_valid_q;
	assign hit_id    = hit_q;
	assign op_done   = done_q;

	`GRCM_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, accept, in_stall)

endmodule

`default_nettype wire

FILE: tb/grcm_checker.sv
`timescale 1ns / 1ps
// Result checker for the grid rectangle collision map: keeps its own copy of the
// grid and the map registers, predicts each result and compares it. Uses grcm_pkg.
module grcm_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [1:0]        func,
	input  logic signed [8:0] pos_x,
	input  logic signed [8:0] pos_y,
	input  logic [6:0]        rect_width,
	input  logic [6:0]        rect_height,
	input  logic signed [5:0] momentum_x,
	input  logic signed [5:0] momentum_y,
	input  logic signed [5:0] excess_x,
	input  logic signed [5:0] excess_y,
	input  logic [2:0]        step_multiplier,
	input  logic [7:0]        owner_id,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [7:0]        hit_id,
	input  logic              op_done,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [7:0]        cfg_data,
	output int                failures,
	output int                pending,
	output int                results_checked,
	output int                wall_answers,
	output int                occupant_answers
);

	localparam int COLS = grcm_pkg::GRID_COLS_DEF;
	localparam int ROWS = grcm_pkg::GRID_ROWS_DEF;

	typedef struct packed {
		logic [7:0] hit;
		logic       done;
		logic       walled;
	} grid_answer_t;

	// Shadow grid and map registers
	logic [7:0]   owner_grid [0:COLS*ROWS-1];
	logic [6:0]   map_cols_reg;
	logic [6:0]   map_rows_reg;
	logic [7:0]   wall_reg;
	grid_answer_t answer_q [$];

	// Apply one operation to the shadow grid and return the answer it gives
	function automatic grid_answer_t apply_grid_op(input logic [1:0] fn, input int px,
			input int py, input int rw, input int rh, input int mx, input int my,
			input int ex, input int ey, input int mult, input logic [7:0] id);
		int cols;
		int rows;
		int x;
		int y;
		int k;
		grid_answer_t ans;
		cols = (map_cols_reg > COLS) ? COLS : int'(map_cols_reg);
		rows = (map_rows_reg > ROWS) ? ROWS : int'(map_rows_reg);
		ans = '{hit: 8'd0, done: 1'b1, walled: 1'b0};
		case (fn)
			grcm_pkg::FUNC_CHECK: begin
				if (mult != 0) begin
					px = px + mx * mult + ex;
					py = py + my * mult + ey;
				end
				// Raster scan; once off the map the answer is the wall code
				for (y = py; y < py + rh; y++)
					for (x = px; x < px + rw; x++)
						if (!ans.walled) begin
							if (y < 0 || y >= rows || x < 0 || x >= cols)
								ans.walled = 1'b1;
							else if (owner_grid[y*COLS + x] != 8'd0)
								ans.hit = owner_grid[y*COLS + x];
						end
				if (ans.walled)
					ans.hit = wall_reg;
			end
			grcm_pkg::FUNC_STAMP, grcm_pkg::FUNC_ERASE: begin
				// Skip off-map cells
				for (y = py; y < py + rh; y++)
					for (x = px; x < px + rw; x++)
						if (y >= 0 && y < rows && x >= 0 && x < cols) begin
							k = y*COLS + x;
							if (fn == grcm_pkg::FUNC_STAMP)
								owner_grid[k] = id;
							else if (owner_grid[k] == id)
								owner_grid[k] = 8'd0;
						end
			end
			default: ans.done = 1'b0;
		endcase
		return ans;
	endfunction

	// Track register writes, predict accepted beats, compare returned beats
	always @(posedge clk or negedge arst_n) begin : watch_ports
		int k;
		grid_answer_t want;
		if (!arst_n) begin
			for (k = 0; k < COLS*ROWS; k++)
				owner_grid[k] = 8'd0;
			map_cols_reg = 7'd64;
			map_rows_reg = 7'd64;
			wall_reg = 8'd1;
			answer_q.delete();
			failures = 0;
			pending = 0;
			results_checked = 0;
			wall_answers = 0;
			occupant_answers = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					grcm_pkg::CFG_MAP_WIDTH:  map_cols_reg = cfg_data[6:0];
					grcm_pkg::CFG_MAP_HEIGHT: map_rows_reg = cfg_data[6:0];
					grcm_pkg::CFG_WALL_CODE:  wall_reg = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				want = apply_grid_op(func, int'(pos_x), int'(pos_y), int'(rect_width),
					int'(rect_height), int'(momentum_x), int'(momentum_y),
					int'(excess_x), int'(excess_y), int'(step_multiplier), owner_id);
				if (func == grcm_pkg::FUNC_CHECK) begin
					if (want.walled)
						wall_answers++;
					else if (want.hit != 8'd0)
						occupant_answers++;
				end
				answer_q.push_back(want);
			end
			if (out_valid && !out_stall) begin
				results_checked++;
				if (answer_q.size() == 0) begin
					$error("result beat with no operation outstanding: hit_id %0d, op_done %0d",
						hit_id, op_done);
					failures++;
				end else begin
					want = answer_q.pop_front();
					if (hit_id !== want.hit) begin
						$error("hit_id mismatch: expected %0d, actual %0d", want.hit, hit_id);
						failures++;
					end
					if (op_done !== want.done) begin
						$error("op_done mismatch: expected %0d, actual %0d", want.done, op_done);
						failures++;
					end
				end
			end
			pending = answer_q.size();
		end
	end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Top of the collision map testbench: clock, reset, register setup, directed and
// random operations, idle patterns and the verdict. Uses grcm_pkg and grcm_checker.
module testbench;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int PHASES = 9;
	localparam int OPS_PER_PHASE = 100;
	localparam int WATCHDOG_LIMIT = 40000;

	typedef struct {
		logic [1:0]        fn;
		logic signed [8:0] px;
		logic signed [8:0] py;
		logic [6:0]        w;
		logic [6:0]        h;
		logic signed [5:0] mx;
		logic signed [5:0] my;
		logic signed [5:0] ex;
		logic signed [5:0] ey;
		logic [2:0]        mult;
		logic [7:0]        id;
	} grid_op_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [1:0]        func;
	logic signed [8:0] pos_x;
	logic signed [8:0] pos_y;
	logic [6:0]        rect_width;
	logic [6:0]        rect_height;
	logic signed [5:0] momentum_x;
	logic signed [5:0] momentum_y;
	logic signed [5:0] excess_x;
	logic signed [5:0] excess_y;
	logic [2:0]        step_multiplier;
	logic [7:0]        owner_id;
	logic              out_valid;
	logic              out_stall;
	logic [7:0]        hit_id;
	logic              op_done;
	logic              cfg_we;
	logic [1:0]        cfg_index;
	logic [7:0]        cfg_data;

	int failures;
	int pending;
	int results_checked;
	int wall_answers;
	int occupant_answers;

	int send_idle_pct;
	int recv_stall_pct;
	int map_cols_now;
	int map_rows_now;
	int ops_sent;
	int quiet_cycles;

	int phase_width [PHASES] = '{64, 16, 1, 200, 0, 64, 1, 0, 64};
	int phase_height[PHASES] = '{64, 12, 1, 100, 0, 1, 64, 0, 64};
	int phase_wall  [PHASES] = '{1, 255, 128, 42, 254, 1, 119, 0, 255};
	int phase_idle  [PHASES] = '{0, 55, 0, 31, 55, 0, 31, 0, 31};
	int phase_stall [PHASES] = '{0, 0, 55, 31, 0, 55, 31, 0, 31};

	grid_rectangle_collision_map u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .pos_x(pos_x), .pos_y(pos_y),
		.rect_width(rect_width), .rect_height(rect_height),
		.momentum_x(momentum_x), .momentum_y(momentum_y),
		.excess_x(excess_x), .excess_y(excess_y),
		.step_multiplier(step_multiplier), .owner_id(owner_id),
		.out_valid(out_valid), .out_stall(out_stall),
		.hit_id(hit_id), .op_done(op_done),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	grcm_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .pos_x(pos_x), .pos_y(pos_y),
		.rect_width(rect_width), .rect_height(rect_height),
		.momentum_x(momentum_x), .momentum_y(momentum_y),
		.excess_x(excess_x), .excess_y(excess_y),
		.step_multiplier(step_multiplier), .owner_id(owner_id),
		.out_valid(out_valid), .out_stall(out_stall),
		.hit_id(hit_id), .op_done(op_done),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.failures(failures), .pending(pending), .results_checked(results_checked),
		.wall_answers(wall_answers), .occupant_answers(occupant_answers)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Random receiver stall, changed at the falling edge
	always @(negedge clk)
		out_stall = (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);

	// Abort when no beat moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic int rand_between(input int lo, input int hi);
		return lo + int'($urandom_range(hi - lo));
	endfunction

	function automatic grid_op_t rect_op(input logic [1:0] fn, input int px, input int py,
			input int w, input int h, input logic [7:0] id);
		grid_op_t op;
		op = '{fn: fn, px: 9'(px), py: 9'(py), w: 7'(w), h: 7'(h), mx: '0, my: '0,
			ex: '0, ey: '0, mult: '0, id: id};
		return op;
	endfunction

	// Mostly well-formed operations near the map with a small ID pool, some noise
	function automatic grid_op_t random_op();
		int sel;
		int look;
		grid_op_t op;
		sel = int'($urandom_range(99));
		op.mx = 6'(rand_between(-32, 31));
		op.my = 6'(rand_between(-32, 31));
		op.ex = 6'(rand_between(-32, 31));
		op.ey = 6'(rand_between(-32, 31));
		op.mult = 3'($urandom_range(7));
		if (sel < 5) begin
			op.fn = 2'($urandom_range(3));
			op.px = 9'(rand_between(-256, 255));
			op.py = 9'(rand_between(-256, 255));
			op.w = 7'($urandom_range(64));
			op.h = 7'($urandom_range(64));
			op.id = 8'($urandom_range(255));
			return op;
		end
		op.fn = (sel < 50) ? grcm_pkg::FUNC_CHECK : (sel < 75) ? grcm_pkg::FUNC_STAMP :
			(sel < 95) ? grcm_pkg::FUNC_ERASE : FUNC_UNUSED;
		if ($urandom_range(99) < 3) begin
			op.w = 7'(rand_between(1, 64));
			op.h = 7'(rand_between(1, 64));
		end else begin
			op.w = 7'($urandom_range(8));
			op.h = 7'($urandom_range(8));
		end
		if ($urandom_range(99) < 85) begin
			op.px = 9'(rand_between(-3, map_cols_now + 1));
			op.py = 9'(rand_between(-3, map_rows_now + 1));
		end else begin
			op.px = 9'(rand_between(-256, 255));
			op.py = 9'(rand_between(-256, 255));
		end
		op.id = ($urandom_range(99) < 85) ? 8'(rand_between(1, 6)) : 8'($urandom_range(255));
		// Keep most look-ahead offsets small so checks land on the map
		if (op.fn == grcm_pkg::FUNC_CHECK) begin
			look = int'($urandom_range(99));
			if (look < 50) begin
				op.mult = 3'd0;
			end else if (look < 85) begin
				op.mult = 3'(rand_between(1, 7));
				op.mx = 6'(rand_between(-2, 2));
				op.my = 6'(rand_between(-2, 2));
				op.ex = 6'(rand_between(-4, 4));
				op.ey = 6'(rand_between(-4, 4));
			end
		end
		return op;
	endfunction

	// Present one beat after a random gap and hold it until taken
	task automatic send_op(input grid_op_t op);
		@(negedge clk);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		func = op.fn;
		pos_x = op.px;
		pos_y = op.py;
		rect_width = op.w;
		rect_height = op.h;
		momentum_x = op.mx;
		momentum_y = op.my;
		excess_x = op.ex;
		excess_y = op.ey;
		step_multiplier = op.mult;
		owner_id = op.id;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		ops_sent++;
	endtask

	// Hold off the sender until every outstanding result has returned
	task automatic drain_results();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input int value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = 8'(value);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic run_directed();
		grid_op_t op;
		send_op(rect_op(grcm_pkg::FUNC_CHECK, 0, 0, 4, 4, 0));
		send_op(rect_op(grcm_pkg::FUNC_STAMP, 0, 0, 64, 1, 255));
		send_op(rect_op(grcm_pkg::FUNC_CHECK, 0, 0, 64, 1, 0));
		send_op(rect_op(grcm_pkg::FUNC_STAMP, 62, 62, 2, 2, 8'h5A));
		send_op(rect_op(grcm_pkg::FUNC_CHECK, 60, 60, 4, 4, 0));
		send_op(rect_op(grcm_pkg::FUNC_CHECK, 62, 62, 3, 2, 0));
		send_op(rect_op(grcm_pkg::FUNC_CHECK, -256, -256, 1, 1, 0));
		send_op(rect_op(grcm_pkg::FUNC_CHECK, 255, 255, 1, 1, 0));
		// Stamp partly off the map: off-map cells are skipped
		send_op(rect_op(grcm_pkg::FUNC_STAMP, -3, -3, 5, 5, 8'd7));
		send_op(rect_op(grcm_pkg::FUNC_STAMP, 7, 7, 1, 1, 8'd9));
		// Look-ahead that lands back on the map
		op = rect_op(grcm_pkg::FUNC_CHECK, -200, -200, 1, 1, 0);
		op.mx = 31; op.my = 31; op.ex = -10; op.ey = -10; op.mult = 7;
		send_op(op);
		// Look-ahead at its extremes, far off the map
		op = rect_op(grcm_pkg::FUNC_CHECK, 0, 0, 2, 2, 0);
		op.mx = -32; op.my = -32; op.ex = -32; op.ey = -32; op.mult = 7;
		send_op(op);
		// Zero multiplier ignores momentum and excess
		op = rect_op(grcm_pkg::FUNC_CHECK, 0, 0, 1, 1, 0);
		op.mx = 31; op.my = 31; op.ex = 31; op.ey = 31; op.mult = 0;
		send_op(op);
		// Empty rectangles touch nothing, even off the map
		send_op(rect_op(grcm_pkg::FUNC_CHECK, -5, -5, 0, 5, 0));
		send_op(rect_op(grcm_pkg::FUNC_CHECK, -5, -5, 5, 0, 0));
		send_op(rect_op(grcm_pkg::FUNC_STAMP, 3, 3, 0, 64, 8'd200));
		// Erasing ID zero changes nothing
		send_op(rect_op(grcm_pkg::FUNC_ERASE, 0, 0, 4, 4, 8'd0));
		send_op(rect_op(grcm_pkg::FUNC_ERASE, 0, 0, 64, 64, 8'd7));
		send_op(rect_op(grcm_pkg::FUNC_CHECK, 0, 0, 2, 2, 0));
		send_op(rect_op(grcm_pkg::FUNC_CHECK, 0, 0, 64, 64, 0));
		op = rect_op(FUNC_UNUSED, 10, 10, 3, 3, 8'd5);
		op.mult = 3;
		send_op(op);
		send_op(rect_op(grcm_pkg::FUNC_STAMP, 1, 0, 2, 1, 8'd0));
		send_op(rect_op(grcm_pkg::FUNC_CHECK, 0, 0, 4, 1, 0));
	endtask

	initial begin : stimulus
		int ph;
		int width_val;
		int height_val;
		int wall_val;
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = grcm_pkg::FUNC_CHECK;
		pos_x = '0;
		pos_y = '0;
		rect_width = '0;
		rect_height = '0;
		momentum_x = '0;
		momentum_y = '0;
		excess_x = '0;
		excess_y = '0;
		step_multiplier = '0;
		owner_id = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = grcm_pkg::CFG_MAP_WIDTH;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		ops_sent = 0;
		quiet_cycles = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (ph = 0; ph < PHASES; ph++) begin
			// Reprogram the map only once the block has gone idle
			drain_results();
			repeat (8) @(negedge clk);
			width_val = (ph == 7) ? rand_between(2, 63) : phase_width[ph];
			height_val = (ph == 7) ? rand_between(2, 63) : phase_height[ph];
			wall_val = (ph == 7) ? rand_between(1, 255) : phase_wall[ph];
			write_reg(grcm_pkg::CFG_MAP_WIDTH, width_val);
			write_reg(grcm_pkg::CFG_MAP_HEIGHT, height_val);
			write_reg(grcm_pkg::CFG_WALL_CODE, wall_val);
			map_cols_now = ((width_val & 8'h7F) > 64) ? 64 : (width_val & 8'h7F);
			map_rows_now = ((height_val & 8'h7F) > 64) ? 64 : (height_val & 8'h7F);
			send_idle_pct = phase_idle[ph];
			recv_stall_pct = phase_stall[ph];
			if (ph == 0)
				run_directed();
			repeat (OPS_PER_PHASE) begin
				send_op(random_op());
				if ($urandom_range(99) == 0)
					drain_results();
			end
		end

		drain_results();
		repeat (40) @(negedge clk);
		$display("Ran %0d operations over %0d map settings; %0d result beats compared.",
			ops_sent, PHASES, results_checked);
		$display("Checks answered the wall code %0d times and an occupant ID %0d times.",
			wall_answers, occupant_answers);
		if (failures == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
